>>> hw/rtl/tsg_pkg.sv
// ----------------------------------------------------------------------------
// tsg_pkg
// Shared constants, codes and control types for the triangle span generator.
// ----------------------------------------------------------------------------
`default_nettype none

package tsg_pkg;

    // Default geometry of the coordinate and fixed-point formats.
    localparam int COORD_BITS_DEF = 13;
    localparam int FRAC_BITS_DEF  = 16;

    // Window registers.
    localparam int CFG_BITS      = 13;
    localparam int CFG_ADDR_BITS = 1;
    localparam int MAX_SCREEN    = 4096;
    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(640);
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(480);
    localparam logic [CFG_ADDR_BITS-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SCREEN_HEIGHT = 1'b1;

    // Result field widths.
    localparam int OUT_BITS   = 12;
    localparam int COLOR_BITS = 32;

    // Setup divisions, run in this order after a load.
    typedef enum logic [2:0] {
        DIV_SPLIT = 3'd0,
        DIV_DOWN0 = 3'd1,
        DIV_DOWN1 = 3'd2,
        DIV_UP0   = 3'd3,
        DIV_UP1   = 3'd4
    } div_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    mul_en;
        logic    div_start;
        logic    div_store;
        div_op_t op;
        logic    init;
        logic    step_down;
        logic    step_up;
        logic    to_up;
        logic    out_load;
        logic    out_span;
        logic    out_last;
    } tsg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic flat_top;
        logic flat_bottom;
        logic down_end;
        logic up_end;
        logic div_done;
        logic div_busy;
        logic out_full;
    } tsg_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/tsg_div.sv
// ----------------------------------------------------------------------------
// tsg_div
// Radix-2 restoring divider, signed dividend by unsigned divisor, quotient
// truncated toward zero. A zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module tsg_div #(
    parameter int NW = 31,
    parameter int DV = 14
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic signed [NW-1:0] dividend,
    input  wire logic        [DV-1:0] divisor,
    output logic                      busy,
    output logic                      done,
    output logic signed [NW-1:0]      quotient
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] quo_reg;
    logic [DV-1:0] rem_reg;
    logic [DV-1:0] den_reg;
    logic          neg_reg;
    logic          zero_reg;

    logic [DV:0]   trial;
    logic          ge;
    logic [DV:0]   diff;

    // One quotient bit per cycle.
    always_comb begin
        trial = {rem_reg, quo_reg[NW-1]};
        ge    = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
    end

    // Control state of the iteration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg  <= dividend[NW-1] ? NW'(-dividend) : dividend;
            rem_reg  <= '0;
            den_reg  <= divisor;
            neg_reg  <= dividend[NW-1];
            zero_reg <= divisor == '0;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[NW-2:0], ge};
            rem_reg <= ge ? diff[DV-1:0] : trial[DV-1:0];
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = zero_reg ? '0 : (neg_reg ? NW'(-quo_reg) : quo_reg);

endmodule

`default_nettype wire

>>> hw/rtl/tsg_datapath.sv
// ----------------------------------------------------------------------------
// tsg_datapath
// Vertex sort, split and slope setup, edge accumulators, span clipping and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsg_datapath
    import tsg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire tsg_cmd_t                      cmd,
    output tsg_status_t                        stat,
    input  wire logic        [CFG_BITS-1:0]    screen_width,
    input  wire logic        [CFG_BITS-1:0]    screen_height,
    input  wire logic signed [COORD_BITS-1:0]  ax,
    input  wire logic signed [COORD_BITS-1:0]  ay,
    input  wire logic signed [COORD_BITS-1:0]  bx,
    input  wire logic signed [COORD_BITS-1:0]  by,
    input  wire logic signed [COORD_BITS-1:0]  cx,
    input  wire logic signed [COORD_BITS-1:0]  cy,
    input  wire logic        [COLOR_BITS-1:0]  fill_color,
    input  wire logic                          m_ready,
    output logic                               m_valid,
    output logic                               span_valid,
    output logic                               visible,
    output logic             [OUT_BITS-1:0]    row,
    output logic             [OUT_BITS-1:0]    left_col,
    output logic             [OUT_BITS-1:0]    right_col,
    output logic             [COLOR_BITS-1:0]  color_out,
    output logic                               last
);

    localparam int C  = COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int XW = C + 1;
    localparam int DX = C + 2;
    localparam int PW = 2 * XW;
    localparam int NW = (PW > DX + F) ? PW : DX + F;
    localparam int AW = C + F + 2;
    localparam int TW = AW - F;
    localparam int KW = ((TW > CFG_BITS + 1) ? TW : CFG_BITS + 1) + 1;

    // Sorted vertices, split column, product, slopes and accumulators.
    logic signed [C-1:0]  x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg;
    logic signed [XW-1:0] mx_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] sd0_reg, sd1_reg, su0_reg, su1_reg;
    logic signed [AW-1:0] acc0_reg, acc1_reg;
    logic signed [C-1:0]  row_reg;
    logic [COLOR_BITS-1:0] color_reg;

    // Result register.
    logic                  m_valid_reg;
    logic                  span_valid_reg, visible_reg, last_reg;
    logic [OUT_BITS-1:0]   row_out_reg, left_reg, right_reg;
    logic [COLOR_BITS-1:0] color_out_reg;

    // Sort network of three compare-and-swap passes, stable on equal rows.
    logic signed [C-1:0] sx [3];
    logic signed [C-1:0] sy [3];
    logic signed [C-1:0] tx, ty;
    always_comb begin
        tx = '0;
        ty = '0;
        sx[0] = ax; sy[0] = ay;
        sx[1] = bx; sy[1] = by;
        sx[2] = cx; sy[2] = cy;
        if (sy[0] > sy[1]) begin
            tx = sx[0]; ty = sy[0];
            sx[0] = sx[1]; sy[0] = sy[1];
            sx[1] = tx; sy[1] = ty;
        end
        if (sy[1] > sy[2]) begin
            tx = sx[1]; ty = sy[1];
            sx[1] = sx[2]; sy[1] = sy[2];
            sx[2] = tx; sy[2] = ty;
        end
        if (sy[0] > sy[1]) begin
            tx = sx[0]; ty = sy[0];
            sx[0] = sx[1]; sy[0] = sy[1];
            sx[1] = tx; sy[1] = ty;
        end
    end

    // Differences used by the setup divisions.
    logic signed [XW-1:0] x1_e, x2_e, x3_e;
    logic [XW-1:0]        dy21, dy31, dy32;
    logic signed [DX-1:0] dxs;
    logic signed [NW-1:0] div_num;
    logic [XW-1:0]        div_den;
    logic signed [NW-1:0] div_q;
    logic                 div_busy, div_done;

    always_comb begin
        x1_e = XW'(x1_reg);
        x2_e = XW'(x2_reg);
        x3_e = XW'(x3_reg);
        dy21 = XW'(y2_reg) - XW'(y1_reg);
        dy31 = XW'(y3_reg) - XW'(y1_reg);
        dy32 = XW'(y3_reg) - XW'(y2_reg);
        case (cmd.op)
            DIV_DOWN0: begin
                dxs = DX'(x2_e) - DX'(x1_e);
                div_den = dy21;
            end
            DIV_DOWN1: begin
                dxs = DX'(mx_reg) - DX'(x1_e);
                div_den = dy21;
            end
            DIV_UP0: begin
                dxs = DX'(x3_e) - DX'(x2_e);
                div_den = dy32;
            end
            DIV_UP1: begin
                dxs = DX'(x3_e) - DX'(mx_reg);
                div_den = dy32;
            end
            default: begin
                dxs = '0;
                div_den = dy31;
            end
        endcase
        if (cmd.op == DIV_SPLIT) begin
            div_num = NW'(prod_reg);
        end else begin
            div_num = NW'(dxs) <<< F;
        end
    end

    tsg_div #(
        .NW (NW),
        .DV (XW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    logic flat_bottom, flat_top;
    assign flat_bottom = y2_reg == y3_reg;
    assign flat_top    = (y1_reg == y2_reg) && !flat_bottom;

    // Vertex and setup registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x1_reg <= sx[0]; y1_reg <= sy[0];
            x2_reg <= sx[1]; y2_reg <= sy[1];
            x3_reg <= sx[2]; y3_reg <= sy[2];
            color_reg <= fill_color;
        end
        if (cmd.mul_en) begin
            prod_reg <= (x3_e - x1_e) * $signed(dy21);
        end
        if (cmd.div_store) begin
            case (cmd.op)
                DIV_SPLIT: begin
                    if (flat_bottom) begin
                        mx_reg <= x3_e;
                    end else if (flat_top) begin
                        mx_reg <= x1_e;
                    end else begin
                        mx_reg <= div_q[XW-1:0] + x1_e;
                    end
                end
                DIV_DOWN0: sd0_reg <= div_q[AW-1:0];
                DIV_DOWN1: sd1_reg <= div_q[AW-1:0];
                DIV_UP0:   su0_reg <= div_q[AW-1:0];
                default:   su1_reg <= div_q[AW-1:0];
            endcase
        end
    end

    // Edge accumulators and current row.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc0_reg <= '0;
            acc1_reg <= '0;
            row_reg  <= '0;
        end else if ((cmd.init && flat_top) || cmd.to_up) begin
            acc0_reg <= AW'(x3_reg) <<< F;
            acc1_reg <= AW'(x3_reg) <<< F;
            row_reg  <= y3_reg;
        end else if (cmd.init) begin
            acc0_reg <= AW'(x1_reg) <<< F;
            acc1_reg <= AW'(x1_reg) <<< F;
            row_reg  <= y1_reg;
        end else if (cmd.step_down) begin
            acc0_reg <= acc0_reg + sd0_reg;
            acc1_reg <= acc1_reg + sd1_reg;
            row_reg  <= row_reg + 1'b1;
        end else if (cmd.step_up) begin
            acc0_reg <= acc0_reg - su0_reg;
            acc1_reg <= acc1_reg - su1_reg;
            row_reg  <= row_reg - 1'b1;
        end
    end

    // Span ends truncated toward zero, then clipped to the window.
    logic signed [TW-1:0] a_t, b_t, lo_t, hi_t;
    logic signed [KW-1:0] lo_k, hi_k, row_k, w_k, h_k;
    logic                 vis;
    always_comb begin
        a_t = TW'(acc0_reg >>> F)
            + TW'(acc0_reg[AW-1] && (acc0_reg[F-1:0] != '0));
        b_t = TW'(acc1_reg >>> F)
            + TW'(acc1_reg[AW-1] && (acc1_reg[F-1:0] != '0));
        lo_t = (a_t < b_t) ? a_t : b_t;
        hi_t = (a_t < b_t) ? b_t : a_t;
        lo_k = KW'(lo_t);
        hi_k = KW'(hi_t);
        row_k = KW'(row_reg);
        w_k = (screen_width > CFG_BITS'(MAX_SCREEN)) ? KW'(MAX_SCREEN)
            : KW'({1'b0, screen_width});
        h_k = (screen_height > CFG_BITS'(MAX_SCREEN)) ? KW'(MAX_SCREEN)
            : KW'({1'b0, screen_height});
        vis = (row_k >= 0) && (row_k < h_k) && (hi_k >= 0) && (lo_k < w_k);
        if (lo_k < 0) begin
            lo_k = '0;
        end
        if (hi_k > w_k - 1) begin
            hi_k = w_k - 1;
        end
    end

    // Result register; it takes a new result on each load command, when it is empty or the old one leaves.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            span_valid_reg <= cmd.out_span;
            visible_reg    <= cmd.out_span && vis;
            row_out_reg    <= (cmd.out_span && vis) ? row_k[OUT_BITS-1:0] : '0;
            left_reg       <= (cmd.out_span && vis) ? lo_k[OUT_BITS-1:0] : '0;
            right_reg      <= (cmd.out_span && vis) ? hi_k[OUT_BITS-1:0] : '0;
            color_out_reg  <= cmd.out_span ? color_reg : '0;
            last_reg       <= cmd.out_span && cmd.out_last;
        end
    end

    always_comb begin
        stat.flat_top    = flat_top;
        stat.flat_bottom = flat_bottom;
        stat.down_end    = row_reg >= y2_reg;
        stat.up_end      = row_reg <= y2_reg;
        stat.div_done    = div_done;
        stat.div_busy    = div_busy;
        stat.out_full    = m_valid_reg;
    end

    assign m_valid    = m_valid_reg;
    assign span_valid = span_valid_reg;
    assign visible    = visible_reg;
    assign row        = row_out_reg;
    assign left_col   = left_reg;
    assign right_col  = right_reg;
    assign color_out  = color_out_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

>>> hw/rtl/tsg_ctrl.sv
// ----------------------------------------------------------------------------
// tsg_ctrl
// Controller: accepts items, sequences the setup after a load and walks the
// two triangle halves one span per step item; in idle a step item yields no span.
// ----------------------------------------------------------------------------
`default_nettype none

module tsg_ctrl
    import tsg_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_mode,
    input  wire logic        m_ready,
    output logic             s_ready,
    input  wire tsg_status_t stat,
    output tsg_cmd_t         cmd
);

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_DOWN      = 7'b0000010,
        ST_UP        = 7'b0000100,
        ST_MUL       = 7'b0001000,
        ST_DIV_START = 7'b0010000,
        ST_DIV_WAIT  = 7'b0100000,
        ST_INIT      = 7'b1000000
    } state_t;

    state_t  state_reg, state_next;
    div_op_t op_reg, op_next;
    logic    walking;
    logic    accept;

    assign walking = (state_reg == ST_IDLE) || (state_reg == ST_DOWN)
                  || (state_reg == ST_UP);
    assign s_ready = walking && (!stat.out_full || m_ready);
    assign accept  = s_valid && s_ready;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        case (state_reg)
            ST_IDLE, ST_DOWN, ST_UP: begin
                if (accept) begin
                    cmd.out_load = 1'b1;
                    if (!s_mode) begin
                        cmd.load   = 1'b1;
                        state_next = ST_MUL;
                    end else if (state_reg == ST_DOWN) begin
                        cmd.out_span = 1'b1;
                        if (stat.down_end) begin
                            if (stat.flat_bottom) begin
                                cmd.out_last = 1'b1;
                                state_next   = ST_IDLE;
                            end else begin
                                cmd.to_up  = 1'b1;
                                state_next = ST_UP;
                            end
                        end else begin
                            cmd.step_down = 1'b1;
                        end
                    end else if (state_reg == ST_UP) begin
                        cmd.out_span = 1'b1;
                        if (stat.up_end) begin
                            cmd.out_last = 1'b1;
                            state_next   = ST_IDLE;
                        end else begin
                            cmd.step_up = 1'b1;
                        end
                    end
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                op_next    = DIV_SPLIT;
                state_next = ST_DIV_START;
            end
            ST_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (stat.div_done) begin
                    cmd.div_store = 1'b1;
                    case (op_reg)
                        DIV_SPLIT: op_next = DIV_DOWN0;
                        DIV_DOWN0: op_next = DIV_DOWN1;
                        DIV_DOWN1: op_next = DIV_UP0;
                        DIV_UP0:   op_next = DIV_UP1;
                        default:   op_next = DIV_SPLIT;
                    endcase
                    state_next = (op_reg == DIV_UP1) ? ST_INIT : ST_DIV_START;
                end
            end
            ST_INIT: begin
                cmd.init   = 1'b1;
                state_next = stat.flat_top ? ST_UP : ST_DOWN;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= DIV_SPLIT;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    // A load always starts the setup sequence.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_mode) |=> (state_reg == ST_MUL))
        else $error("load did not start setup");

    // The divider reports completion only while the controller waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished outside wait state");

    // No item is taken while a setup division runs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_busy |-> !s_ready)
        else $error("input ready during setup division");

    // Initialization always leads into the down or the up walk.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INIT) |=> (state_reg == ST_DOWN || state_reg == ST_UP))
        else $error("init did not enter a walk state");

endmodule

`default_nettype wire

>>> hw/rtl/triangle_span_generator_top.sv
// ----------------------------------------------------------------------------
// triangle_span_generator_top
// Scan-converts a filled triangle into clipped horizontal spans.
// ----------------------------------------------------------------------------
//  Channel  | Ports                                   | Direction
//  ---------+-----------------------------------------+----------
//  input    | s_valid/s_ready, s_mode, s_ax..s_cy,    | in
//           | s_fill_color                            |
//  result   | m_valid/m_ready, m_span_valid, m_row,   | out
//           | m_visible, m_left_col, m_right_col,     |
//           | m_color_out, m_last                     |
//  config   | cfg_wr_en, cfg_addr, cfg_wr_data        | in
//
// Step items issue spans back to back while the result register is not stalled.
// A load item returns a result with no span, then holds the input closed while the NW-bit
// shared serial divider computes the split column and then the down and up edge slopes,
// NW = max(2*COORD_BITS+2, COORD_BITS+FRAC_BITS+2).
// Reset is synchronous and active low; a stalled result keeps the input closed
// only when the result register is full and not taken.
`default_nettype none

module triangle_span_generator_top
    import tsg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic        [CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic        [CFG_BITS-1:0]   cfg_wr_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_mode,
    input  wire logic signed [COORD_BITS-1:0] s_ax,
    input  wire logic signed [COORD_BITS-1:0] s_ay,
    input  wire logic signed [COORD_BITS-1:0] s_bx,
    input  wire logic signed [COORD_BITS-1:0] s_by,
    input  wire logic signed [COORD_BITS-1:0] s_cx,
    input  wire logic signed [COORD_BITS-1:0] s_cy,
    input  wire logic        [COLOR_BITS-1:0] s_fill_color,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_span_valid,
    output logic                              m_visible,
    output logic             [OUT_BITS-1:0]   m_row,
    output logic             [OUT_BITS-1:0]   m_left_col,
    output logic             [OUT_BITS-1:0]   m_right_col,
    output logic             [COLOR_BITS-1:0] m_color_out,
    output logic                              m_last
);

    logic [CFG_BITS-1:0] width_reg;
    logic [CFG_BITS-1:0] height_reg;
    tsg_cmd_t            cmd;
    tsg_status_t         stat;

    // Window registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_addr == REG_SCREEN_WIDTH) begin
                width_reg <= cfg_wr_data;
            end
            if (cfg_addr == REG_SCREEN_HEIGHT) begin
                height_reg <= cfg_wr_data;
            end
        end
    end

    tsg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_mode),
        .m_ready (m_ready),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tsg_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .ax            (s_ax),
        .ay            (s_ay),
        .bx            (s_bx),
        .by            (s_by),
        .cx            (s_cx),
        .cy            (s_cy),
        .fill_color    (s_fill_color),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .span_valid    (m_span_valid),
        .visible       (m_visible),
        .row           (m_row),
        .left_col      (m_left_col),
        .right_col     (m_right_col),
        .color_out     (m_color_out),
        .last          (m_last)
    );

endmodule

`default_nettype wire
